[rtl/siphash_pkg.sv]
package siphash_pkg;

    // SipHash initialization constants
    localparam logic [63:0] SIP_C0 = 64'h736F6D6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646F72616E646F6D;
    localparam logic [63:0] SIP_C2 = 64'h6C7967656E657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    // Finalization xor into lane c, and the position of the length byte
    localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000FF;
    localparam int unsigned SIP_LEN_SHIFT = 56;

    // Bytes in one message word
    localparam int unsigned WORD_BYTES = 8;
    localparam logic [3:0]  FULL_COUNT = 4'd8;

    // The four SipHash lanes
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_lanes;

    // Keep the low cnt bytes of a word, clear the rest
    function automatic logic [63:0] byte_mask(input logic [63:0] word, input logic [3:0] cnt);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < WORD_BYTES; i++) begin
            if (4'(i) < cnt) begin
                res[i*8 +: 8] = word[i*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

[rtl/siphash_if.sv]
// Message word channel
interface siphash_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

// Digest channel
interface siphash_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;

    modport source (output valid, output digest, input ready);
    modport sink   (input valid, input digest, output ready);
endinterface

[rtl/siphash_round.sv]
module siphash_round
    import siphash_pkg::*;
(
    input  t_lanes i_lanes,
    output t_lanes o_lanes
);

    logic [63:0] a1, a2, a3;
    logic [63:0] b1, b2;
    logic [63:0] c1, c2;
    logic [63:0] d1, d2;

    // First half-round: add, rotate, xor on both lane pairs
    assign a1 = i_lanes.a + i_lanes.b;
    assign b1 = {i_lanes.b[50:0], i_lanes.b[63:51]} ^ a1;
    assign a2 = {a1[31:0], a1[63:32]};
    assign c1 = i_lanes.c + i_lanes.d;
    assign d1 = {i_lanes.d[47:0], i_lanes.d[63:48]} ^ c1;

    // Second half-round: cross the pairs
    assign a3 = a2 + d1;
    assign d2 = {d1[42:0], d1[63:43]} ^ a3;
    assign c2 = c1 + b1;
    assign b2 = {b1[46:0], b1[63:47]} ^ c2;

    assign o_lanes.a = a3;
    assign o_lanes.b = b2;
    assign o_lanes.c = {c2[31:0], c2[63:32]};
    assign o_lanes.d = d2;

endmodule

[rtl/siphash_core.sv]
module siphash_core
    import siphash_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [63:0]          i_key_low,
    input  logic [63:0]          i_key_high,
    siphash_in_if.sink           i_in,
    siphash_out_if.source        o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ABSORB,
        S_FINAL,
        S_MIX
    } t_state;

    t_state      r_state;
    logic [1:0]  r_rnd;
    logic        r_in_msg;
    logic        r_last;
    logic [7:0]  r_bt;
    logic [63:0] r_word;
    logic [63:0] r_fin;
    t_lanes      r_lanes;
    logic        r_out_valid;
    logic [63:0] r_digest;

    t_lanes      round_out;
    t_lanes      absorb_done;
    t_lanes      final_start;
    t_lanes      mix_start;
    t_lanes      base;
    t_lanes      seed;
    t_lanes      seed_mix;
    logic        accept;
    logic        full;
    logic [3:0]  cnt_sat;
    logic [7:0]  bt_base;
    logic [7:0]  bt_new;
    logic [63:0] fin;
    logic        out_free;
    logic        digest_load;

    // Shared round unit
    siphash_round u_round (
        .i_lanes (r_lanes),
        .o_lanes (round_out)
    );

    // Second round of a block with the message word folded into lane a
    always_comb begin
        absorb_done   = round_out;
        absorb_done.a = round_out.a ^ r_word;
    end

    // Fold the final block into lane d after an eight-byte last word
    always_comb begin
        final_start   = absorb_done;
        final_start.d = absorb_done.d ^ r_fin;
    end

    // Close the final block and apply the finalization xor
    always_comb begin
        mix_start   = round_out;
        mix_start.a = round_out.a ^ r_fin;
        mix_start.c = round_out.c ^ SIP_FINAL_XOR;
    end

    // Take a new item when idle or as a full block finishes its second round
    assign i_in.ready  = (r_state == S_IDLE) ||
                         (r_state == S_ABSORB && r_rnd == 2'd1 && !r_last);
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign digest_load = (r_state == S_MIX) && (r_rnd == 2'd3) && out_free;

    // Seed the lanes on the first word of a message
    always_comb begin
        base = (r_state == S_IDLE) ? r_lanes : absorb_done;
        if (!r_in_msg) begin
            seed.a = SIP_C0 ^ i_key_low;
            seed.b = SIP_C1 ^ i_key_high;
            seed.c = SIP_C2 ^ i_key_low;
            seed.d = SIP_C3 ^ i_key_high;
        end else begin
            seed = base;
        end
    end

    // Form the byte total and the final block
    always_comb begin
        cnt_sat = (i_in.byte_count > FULL_COUNT) ? FULL_COUNT : i_in.byte_count;
        full    = !i_in.last || (cnt_sat == FULL_COUNT);
        bt_base = r_in_msg ? r_bt : 8'd0;
        bt_new  = full ? (bt_base + 8'd8) : (bt_base + {4'd0, cnt_sat});
        fin     = full ? 64'd0 : byte_mask(i_in.data_word, cnt_sat);
        fin[SIP_LEN_SHIFT +: 8] = bt_new;
    end

    // Fold the incoming block into lane d
    always_comb begin
        seed_mix   = seed;
        seed_mix.d = seed.d ^ (full ? i_in.data_word : fin);
    end

    // Sequencer, lanes and digest register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rnd       <= 2'd0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid as the last round lands, drop it once taken
            if (digest_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_lanes   <= seed_mix;
                r_word    <= i_in.data_word;
                r_fin     <= fin;
                r_last    <= i_in.last;
                r_bt      <= bt_new;
                r_in_msg  <= !i_in.last;
                r_rnd     <= 2'd0;
                r_state   <= full ? S_ABSORB : S_FINAL;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                    end
                    S_ABSORB: begin
                        if (r_rnd == 2'd1) begin
                            r_rnd <= 2'd0;
                            if (r_last) begin
                                r_lanes <= final_start;
                                r_state <= S_FINAL;
                            end else begin
                                r_lanes <= absorb_done;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_lanes <= round_out;
                            r_rnd   <= r_rnd + 2'd1;
                        end
                    end
                    S_FINAL: begin
                        if (r_rnd == 2'd1) begin
                            r_lanes <= mix_start;
                            r_rnd   <= 2'd0;
                            r_state <= S_MIX;
                        end else begin
                            r_lanes <= round_out;
                            r_rnd   <= r_rnd + 2'd1;
                        end
                    end
                    S_MIX: begin
                        if (r_rnd == 2'd3) begin
                            // Hold the last round until the digest register is free
                            if (out_free) begin
                                r_lanes  <= round_out;
                                r_digest <= round_out.a ^ round_out.b ^
                                            round_out.c ^ round_out.d;
                                r_rnd    <= 2'd0;
                                r_state  <= S_IDLE;
                            end
                        end else begin
                            r_lanes <= round_out;
                            r_rnd   <= r_rnd + 2'd1;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.digest = r_digest;

endmodule

[rtl/siphash_keyed_hash_top.sv]
// SipHash-2-4 keyed hash over a byte message streamed as little-endian 64-bit
// words. Load the 128-bit key through the APB port (key_low at byte address 0,
// key_high at 8, 64-bit data), then send the message one item per word with
// last set on the final item, whose byte_count gives 0 to 8 valid bytes. One
// digest item follows each message. A single SipRound unit runs one round per
// cycle: a full word runs 2 rounds and the next item can enter as its second
// round completes. A last item with 0 to 7 bytes runs 2 rounds on the final
// block and 4 finalization rounds; one with 8 bytes runs 2 rounds on the word
// before those, and the block then returns to idle. The digest sits in an
// output register, so the next message can start while it waits; a second
// digest stalls the final round until the first is taken. Change the key only
// between messages.
module siphash_keyed_hash_top
    import siphash_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    siphash_in_if.sink    i_in,
    siphash_out_if.source o_out
);

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Key registers, one per 8-byte slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_key_high <= pwdata;
            end else begin
                r_key_low <= pwdata;
            end
        end
    end

    // Read back the addressed key word
    assign prdata = paddr[3] ? r_key_high : r_key_low;

    siphash_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

[rtl/siphash_keyed_hash_checker.sv]
module siphash_keyed_hash_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_digest
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A stalled digest holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_digest))
        else $error("digest changed or dropped while stalled");

    // A full word drops ready, then raises it again as its second round completes
    a_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_last |=> !i_in_ready ##1 i_in_ready)
        else $error("full word did not take two cycles");

    // A last item keeps the block busy for at least the final-block and finalization rounds
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_last |=> !i_in_ready ##1 !i_in_ready ##1 !i_in_ready
                                ##1 !i_in_ready ##1 !i_in_ready ##1 !i_in_ready)
        else $error("block ready too early after last item");

    // No digest straight out of reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("digest valid after reset");

endmodule

bind siphash_keyed_hash_top siphash_keyed_hash_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_last    (i_in.last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_digest (o_out.digest)
);
